// ----- src/cdq_pkg.sv -----
`timescale 1ns / 1ps
package cdq_pkg;

  localparam logic [3:0] CMD_PUSH_REAR  = 4'd0;
  localparam logic [3:0] CMD_POP        = 4'd1;
  localparam logic [3:0] CMD_PEEK       = 4'd2;
  localparam logic [3:0] CMD_PUSH_FRONT = 4'd3;
  localparam logic [3:0] CMD_MEMBER     = 4'd4;
  localparam logic [3:0] CMD_READ_OFF   = 4'd5;
  localparam logic [3:0] CMD_WRITE_OFF  = 4'd6;
  localparam logic [3:0] CMD_OVERWRITE  = 4'd7;
  localparam logic [3:0] CMD_CLEAR      = 4'd8;

  localparam logic [7:0] EMPTY_POP_BYTE = 8'h20;

  typedef enum logic [3:0] {
    OP_PUSH_REAR,
    OP_POP,
    OP_PEEK,
    OP_PUSH_FRONT,
    OP_MEMBER,
    OP_READ_OFF,
    OP_WRITE_OFF,
    OP_OVERWRITE,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic [3:0] index;
  } cmd_item_t;

endpackage

// ----- src/cdq_ram.sv -----
`timescale 1ns / 1ps
module cdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/cdq_front.sv -----
`timescale 1ns / 1ps
module cdq_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_command,
  input  logic [7:0]         in_data_in,
  input  logic [3:0]         in_index,
  input  logic               busy,
  output logic               q_valid,
  output cdq_pkg::cmd_item_t q_item,
  input  logic               q_pop
);

  cdq_pkg::cmd_item_t mem_r [2];
  logic               wr_r, wr_nxt;
  logic               rd_r, rd_nxt;
  logic [1:0]         cnt_r, cnt_nxt;
  logic               accept;
  cdq_pkg::cmd_item_t new_item;

  always_comb begin
    new_item.data  = in_data_in;
    new_item.index = in_index;
    case (in_command)
      cdq_pkg::CMD_PUSH_REAR:  new_item.op = cdq_pkg::OP_PUSH_REAR;
      cdq_pkg::CMD_POP:        new_item.op = cdq_pkg::OP_POP;
      cdq_pkg::CMD_PEEK:       new_item.op = cdq_pkg::OP_PEEK;
      cdq_pkg::CMD_PUSH_FRONT: new_item.op = cdq_pkg::OP_PUSH_FRONT;
      cdq_pkg::CMD_MEMBER:     new_item.op = cdq_pkg::OP_MEMBER;
      cdq_pkg::CMD_READ_OFF:   new_item.op = cdq_pkg::OP_READ_OFF;
      cdq_pkg::CMD_WRITE_OFF:  new_item.op = cdq_pkg::OP_WRITE_OFF;
      cdq_pkg::CMD_OVERWRITE:  new_item.op = cdq_pkg::OP_OVERWRITE;
      cdq_pkg::CMD_CLEAR:      new_item.op = cdq_pkg::OP_CLEAR;
      default:                 new_item.op = cdq_pkg::OP_NOP;
    endcase
  end

  assign in_stall = (cnt_r == 2'd2) || busy;
  assign accept   = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rd_r];

  always_comb begin
    wr_nxt  = accept ? !wr_r : wr_r;
    rd_nxt  = q_pop ? !rd_r : rd_r;
    cnt_nxt = cnt_r + 2'(accept) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (accept) begin
      mem_r[wr_r] <= new_item;
    end
  end

endmodule

// ----- src/cdq_back.sv -----
`timescale 1ns / 1ps
module cdq_back #(
  parameter int SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  cdq_pkg::cmd_item_t q_item,
  output logic               q_pop,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_data_out,
  output logic               out_found,
  output logic               out_error,
  output logic [3:0]         out_count,
  output logic               out_empty_res,
  output logic               out_full_res
);

  localparam int AW = $clog2(SLOTS);
  localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_READ, S_SRCH, S_SCMP, S_CLR, S_FIN
  } state_t;

  state_t             state_r, state_nxt;
  cdq_pkg::cmd_item_t item_r, item_nxt;
  logic [AW-1:0]      front_r, front_nxt;
  logic [AW-1:0]      rear_r, rear_nxt;
  logic [AW-1:0]      scan_r, scan_nxt;
  logic [AW-1:0]      left_r, left_nxt;
  logic [AW-1:0]      init_r, init_nxt;
  logic [7:0]         dout_r, dout_nxt;
  logic               found_r, found_nxt;
  logic               err_r, err_nxt;
  logic               ov_r, ov_nxt;
  logic [7:0]         o_data_r;
  logic               o_found_r, o_err_r, o_empty_r, o_full_r;
  logic [3:0]         o_count_r;
  logic               o_load;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [7:0]         ram_wdata, ram_rdata;

  logic [AW-1:0]      idx_tbl [16];
  logic [AW-1:0]      front_inc, front_dec, rear_inc, off_pos;
  logic [AW:0]        off_sum, held_w;
  logic [AW-1:0]      held;
  logic               is_empty, is_full;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == LAST) ? '0 : p + AW'(1);
  endfunction

  for (genvar g = 0; g < 16; g++) begin : g_idx
    assign idx_tbl[g] = AW'(g % SLOTS);
  end

  cdq_ram #(.WIDTH(8), .DEPTH(SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign front_inc = wrap_inc(front_r);
  assign front_dec = (front_r == '0) ? LAST : front_r - AW'(1);
  assign rear_inc  = wrap_inc(rear_r);
  assign off_sum   = {1'b0, front_r} + {1'b0, idx_tbl[q_item.index]};
  assign off_pos   = (off_sum >= (AW+1)'(SLOTS)) ? AW'(off_sum - (AW+1)'(SLOTS))
                                                 : AW'(off_sum);
  assign held_w    = (rear_r >= front_r) ? {1'b0, rear_r} - {1'b0, front_r}
                     : {1'b0, rear_r} + (AW+1)'(SLOTS) - {1'b0, front_r};
  assign held      = AW'(held_w);
  assign is_empty  = (front_r == rear_r);
  assign is_full   = (rear_inc == front_r);
  assign busy      = (state_r == S_INIT);
  assign o_load    = (state_r == S_FIN) && (!ov_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    front_nxt = front_r;
    rear_nxt  = rear_r;
    scan_nxt  = scan_r;
    left_nxt  = left_r;
    init_nxt  = init_r;
    dout_nxt  = dout_r;
    found_nxt = found_r;
    err_nxt   = err_r;
    ov_nxt    = (ov_r && out_stall) || o_load;
    ram_we    = 1'b0;
    ram_waddr = front_r;
    ram_wdata = 8'h00;
    ram_raddr = scan_r;
    q_pop     = 1'b0;
    case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = init_r;
        if (init_r == LAST) begin
          state_nxt = S_IDLE;
        end else begin
          init_nxt = init_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          item_nxt  = q_item;
          dout_nxt  = 8'h00;
          found_nxt = 1'b0;
          err_nxt   = 1'b0;
          state_nxt = S_FIN;
          case (q_item.op)
            cdq_pkg::OP_PUSH_REAR: begin
              if (is_full) begin
                err_nxt = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = rear_inc;
                ram_wdata = q_item.data;
                rear_nxt  = rear_inc;
              end
            end
            cdq_pkg::OP_POP: begin
              if (is_empty) begin
                err_nxt  = 1'b1;
                dout_nxt = cdq_pkg::EMPTY_POP_BYTE;
              end else begin
                front_nxt = front_inc;
                ram_raddr = front_inc;
                state_nxt = S_READ;
              end
            end
            cdq_pkg::OP_PEEK: begin
              ram_raddr = front_inc;
              state_nxt = S_READ;
            end
            cdq_pkg::OP_PUSH_FRONT: begin
              if (is_full) begin
                err_nxt = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = front_r;
                ram_wdata = q_item.data;
                front_nxt = front_dec;
              end
            end
            cdq_pkg::OP_MEMBER: begin
              if (!is_empty) begin
                scan_nxt  = front_inc;
                left_nxt  = held;
                state_nxt = S_SRCH;
              end
            end
            cdq_pkg::OP_READ_OFF: begin
              ram_raddr = off_pos;
              state_nxt = S_READ;
            end
            cdq_pkg::OP_WRITE_OFF: begin
              ram_we    = 1'b1;
              ram_waddr = off_pos;
              ram_wdata = q_item.data;
            end
            cdq_pkg::OP_OVERWRITE: begin
              ram_we    = 1'b1;
              ram_waddr = rear_r;
              ram_wdata = q_item.data;
            end
            cdq_pkg::OP_CLEAR: begin
              state_nxt = S_CLR;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_READ: begin
        dout_nxt  = ram_rdata;
        state_nxt = S_FIN;
        if (item_r.op == cdq_pkg::OP_POP) begin
          ram_we    = 1'b1;
          ram_waddr = front_r;
        end
      end
      S_SRCH: begin
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        if (ram_rdata == item_r.data) begin
          found_nxt = 1'b1;
          state_nxt = S_FIN;
        end else if (left_r == AW'(1)) begin
          state_nxt = S_FIN;
        end else begin
          scan_nxt  = wrap_inc(scan_r);
          left_nxt  = left_r - AW'(1);
          state_nxt = S_SRCH;
        end
      end
      S_CLR: begin
        if (is_empty) begin
          state_nxt = S_FIN;
        end else begin
          front_nxt = front_inc;
          ram_we    = 1'b1;
          ram_waddr = front_inc;
        end
      end
      S_FIN: begin
        if (o_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      front_r <= '0;
      rear_r  <= '0;
      init_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
      init_r  <= init_nxt;
      ov_r    <= ov_nxt;
    end
    item_r  <= item_nxt;
    scan_r  <= scan_nxt;
    left_r  <= left_nxt;
    dout_r  <= dout_nxt;
    found_r <= found_nxt;
    err_r   <= err_nxt;
    if (o_load) begin
      o_data_r  <= dout_r;
      o_found_r <= found_r;
      o_err_r   <= err_r;
      o_count_r <= 4'(held);
      o_empty_r <= is_empty;
      o_full_r  <= is_full;
    end
  end

  assign out_valid     = ov_r;
  assign out_data_out  = o_data_r;
  assign out_found     = o_found_r;
  assign out_error     = o_err_r;
  assign out_count     = o_count_r;
  assign out_empty_res = o_empty_r;
  assign out_full_res  = o_full_r;

endmodule

// ----- src/circular_char_deque.sv -----
`timescale 1ns / 1ps
// Byte deque on a ring of SLOTS entries, one slot always kept free, so it holds at most
// SLOTS-1 bytes. Each command word yields exactly one result word with the data byte and
// the count, empty and full status after the command. Command words enter a two-entry
// queue and are executed one at a time by a sequencer around a single-port-write,
// registered-read RAM. Push rear, push front, write at offset, overwrite newest, unused
// commands and failed pushes or pops go straight to the result; pop, peek and read at
// offset first pass a RAM read state; a member search reads and compares held entries
// until a match or the last one; clear zeroes held entries one at a time. After reset
// the RAM is zeroed one entry a cycle, and no word is accepted until that pass ends.
module circular_char_deque #(
  parameter int SLOTS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] in_command,
  input  logic [7:0] in_data_in,
  input  logic [3:0] in_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_out,
  output logic       out_found,
  output logic       out_error,
  output logic [3:0] out_count,
  output logic       out_empty_res,
  output logic       out_full_res
);

  cdq_pkg::cmd_item_t q_item;
  logic               q_valid;
  logic               q_pop;
  logic               busy;

  cdq_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .in_data_in (in_data_in),
    .in_index   (in_index),
    .busy       (busy),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  cdq_back #(.SLOTS(SLOTS)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .busy          (busy),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data_out  (out_data_out),
    .out_found     (out_found),
    .out_error     (out_error),
    .out_count     (out_count),
    .out_empty_res (out_empty_res),
    .out_full_res  (out_full_res)
  );

`ifndef NO_ASSERTIONS
  a_not_empty_and_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_empty_res && out_full_res))
    else $error("result reports empty and full together");

  a_error_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error) |->
      (out_data_out == cdq_pkg::EMPTY_POP_BYTE || out_data_out == 8'h00))
    else $error("error result carries an unexpected data byte");

  a_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (!out_error && out_data_out == 8'h00))
    else $error("member match reported together with error or data");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_empty_res) |-> (out_count == 4'd0))
    else $error("empty result with a nonzero count");
`endif

endmodule

// ----- test/circular_char_deque_tb.sv -----
`timescale 1ns / 1ps
module circular_char_deque_tb;

  localparam int SLOTS = 16;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_WORDS = 1500;
  localparam int HOLD_CYCLES = 90;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES = 64;

  typedef struct {
    logic [3:0]  command;
    logic [7:0]  data;
    logic [3:0]  index;
    int unsigned gap;
    bit          drain;
  } deque_word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       found;
    logic       error;
    logic [3:0] count;
    logic       empty;
    logic       full;
  } deque_result_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [3:0] in_command;
  logic [7:0] in_data_in;
  logic [3:0] in_index;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_data_out;
  logic       out_found;
  logic       out_error;
  logic [3:0] out_count;
  logic       out_empty_res;
  logic       out_full_res;

  deque_word_t   pending_words[$];
  deque_result_t expected_results[$];

  logic [7:0] ring [SLOTS];
  logic [3:0] head_ptr;
  logic [3:0] tail_ptr;

  deque_word_t   next_word;
  deque_word_t   staged_word;
  deque_result_t want;
  deque_result_t got;
  bit            in_taken;
  bit            word_ready;
  bit            drain_wait;
  int unsigned   gap_left;
  int unsigned   stall_left;
  int unsigned   hold_left;
  int            next_hold_at;
  int            results_seen;
  int            mismatches;
  int            idle_cycles;
  int            random_count;

  circular_char_deque uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_data_in   (in_data_in),
    .in_index     (in_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data_out (out_data_out),
    .out_found    (out_found),
    .out_error    (out_error),
    .out_count    (out_count),
    .out_empty_res(out_empty_res),
    .out_full_res (out_full_res)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 10);
    else return $urandom_range(15, 40);
  endfunction

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 7));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [3:0] pick_command();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) return cdq_pkg::CMD_PUSH_REAR;
    else if (r < 35) return cdq_pkg::CMD_POP;
    else if (r < 42) return cdq_pkg::CMD_PEEK;
    else if (r < 55) return cdq_pkg::CMD_PUSH_FRONT;
    else if (r < 65) return cdq_pkg::CMD_MEMBER;
    else if (r < 75) return cdq_pkg::CMD_READ_OFF;
    else if (r < 83) return cdq_pkg::CMD_WRITE_OFF;
    else if (r < 90) return cdq_pkg::CMD_OVERWRITE;
    else if (r < 93) return cdq_pkg::CMD_CLEAR;
    else return 4'($urandom_range(9, 15));
  endfunction

  task automatic queue_word(input logic [3:0] cmd, input logic [7:0] data,
                            input logic [3:0] idx);
    deque_word_t w;
    w.command = cmd;
    w.data = data;
    w.index = idx;
    w.drain = 1'b0;
    w.gap = (random_count >= 900 && random_count < 1100) ? 0 : pick_gap();
    pending_words.push_back(w);
  endtask

  task automatic queue_pause();
    deque_word_t w;
    w.command = cdq_pkg::CMD_PEEK;
    w.data = 8'h00;
    w.index = 4'h0;
    w.gap = 0;
    w.drain = 1'b1;
    pending_words.push_back(w);
  endtask

  // Applies one command word to the deque image and queues the result it produces.
  task automatic deque_execute(input logic [3:0] cmd, input logic [7:0] data,
                               input logic [3:0] idx);
    deque_result_t r;
    logic [3:0] pos;
    logic [3:0] held;
    int k;
    r = '0;
    case (cmd)
      cdq_pkg::CMD_PUSH_REAR: begin
        pos = tail_ptr + 4'd1;
        if (pos == head_ptr) begin
          r.error = 1'b1;
        end else begin
          ring[pos] = data;
          tail_ptr = pos;
        end
      end
      cdq_pkg::CMD_POP: begin
        if (head_ptr == tail_ptr) begin
          r.error = 1'b1;
          r.data = cdq_pkg::EMPTY_POP_BYTE;
        end else begin
          head_ptr = head_ptr + 4'd1;
          r.data = ring[head_ptr];
          ring[head_ptr] = 8'h00;
        end
      end
      cdq_pkg::CMD_PEEK: begin
        pos = head_ptr + 4'd1;
        r.data = ring[pos];
      end
      cdq_pkg::CMD_PUSH_FRONT: begin
        pos = tail_ptr + 4'd1;
        if (pos == head_ptr) begin
          r.error = 1'b1;
        end else begin
          ring[head_ptr] = data;
          head_ptr = head_ptr - 4'd1;
        end
      end
      cdq_pkg::CMD_MEMBER: begin
        held = tail_ptr - head_ptr;
        for (k = 1; k <= int'(held); k++) begin
          pos = head_ptr + 4'(k);
          if (ring[pos] == data) r.found = 1'b1;
        end
      end
      cdq_pkg::CMD_READ_OFF: begin
        pos = head_ptr + idx;
        r.data = ring[pos];
      end
      cdq_pkg::CMD_WRITE_OFF: begin
        pos = head_ptr + idx;
        ring[pos] = data;
      end
      cdq_pkg::CMD_OVERWRITE: begin
        ring[tail_ptr] = data;
      end
      cdq_pkg::CMD_CLEAR: begin
        while (head_ptr != tail_ptr) begin
          head_ptr = head_ptr + 4'd1;
          ring[head_ptr] = 8'h00;
        end
      end
      default: begin
      end
    endcase
    pos = tail_ptr + 4'd1;
    r.count = tail_ptr - head_ptr;
    r.empty = (head_ptr == tail_ptr);
    r.full = (pos == head_ptr);
    expected_results.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input deque_result_t exp_r,
                                 input deque_result_t act_r);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s) at %0t:", what, $time);
      $display("  expected data=%02h found=%0b error=%0b count=%0d empty=%0b full=%0b",
               exp_r.data, exp_r.found, exp_r.error, exp_r.count, exp_r.empty,
               exp_r.full);
      $display("  got      data=%02h found=%0b error=%0b count=%0d empty=%0b full=%0b",
               act_r.data, act_r.found, act_r.error, act_r.count, act_r.empty,
               act_r.full);
    end
  endtask

  // Sender: one word at a time, held until it is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
    end else if (drain_wait) begin
      in_valid <= 1'b0;
      if (expected_results.size() == 0) drain_wait <= 1'b0;
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (word_ready) begin
      in_valid <= 1'b1;
      in_command <= staged_word.command;
      in_data_in <= staged_word.data;
      in_index <= staged_word.index;
      word_ready <= 1'b0;
    end else if (pending_words.size() > 0) begin
      next_word = pending_words.pop_front();
      if (next_word.drain) begin
        in_valid <= 1'b0;
        drain_wait <= 1'b1;
      end else if (next_word.gap == 0) begin
        in_valid <= 1'b1;
        in_command <= next_word.command;
        in_data_in <= next_word.data;
        in_index <= next_word.index;
      end else begin
        in_valid <= 1'b0;
        staged_word <= next_word;
        word_ready <= 1'b1;
        gap_left <= next_word.gap - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: random stalls, a calm stretch, and occasional long hold-offs.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (results_seen >= next_hold_at) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      next_hold_at <= next_hold_at + 850;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (results_seen >= 500 && results_seen < 700) stall_left <= 0;
      else stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) deque_execute(in_command, in_data_in, in_index);
      if (out_valid && !out_stall) begin
        got.data = out_data_out;
        got.found = out_found;
        got.error = out_error;
        got.count = out_count;
        got.empty = out_empty_res;
        got.full = out_full_res;
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected word", '0, got);
        end else begin
          want = expected_results.pop_front();
          if (got.data !== want.data || got.found !== want.found
              || got.error !== want.error || got.count !== want.count
              || got.empty !== want.empty || got.full !== want.full) begin
            report_mismatch("field", want, got);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles without progress", idle_cycles);
      $display("circular_char_deque verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned kind;
    int unsigned n;
    int j;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = cdq_pkg::CMD_PEEK;
    in_data_in = 8'h00;
    in_index = 4'h0;
    out_stall = 1'b0;
    in_taken = 1'b0;
    word_ready = 1'b0;
    drain_wait = 1'b0;
    gap_left = 0;
    stall_left = 0;
    hold_left = 0;
    next_hold_at = 250;
    results_seen = 0;
    mismatches = 0;
    idle_cycles = 0;
    random_count = 0;
    head_ptr = 4'd0;
    tail_ptr = 4'd0;
    for (j = 0; j < SLOTS; j++) ring[j] = 8'h00;

    queue_word(cdq_pkg::CMD_POP, 8'h00, 4'h0);
    queue_word(cdq_pkg::CMD_PEEK, 8'h00, 4'h0);
    queue_word(cdq_pkg::CMD_MEMBER, 8'h00, 4'h0);
    queue_word(cdq_pkg::CMD_READ_OFF, 8'h00, 4'h0);
    queue_word(cdq_pkg::CMD_OVERWRITE, 8'h5A, 4'h0);
    queue_word(cdq_pkg::CMD_READ_OFF, 8'h00, 4'h0);
    queue_word(cdq_pkg::CMD_PUSH_FRONT, 8'hA5, 4'h0);
    queue_word(cdq_pkg::CMD_PUSH_REAR, 8'h00, 4'h0);
    queue_word(cdq_pkg::CMD_PUSH_REAR, 8'hFF, 4'h0);
    queue_word(cdq_pkg::CMD_MEMBER, 8'hFF, 4'h0);
    queue_word(cdq_pkg::CMD_MEMBER, 8'h7E, 4'h0);
    queue_word(cdq_pkg::CMD_READ_OFF, 8'h00, 4'hF);
    queue_word(cdq_pkg::CMD_WRITE_OFF, 8'h3C, 4'hF);
    queue_word(cdq_pkg::CMD_READ_OFF, 8'hFF, 4'hF);
    queue_word(cdq_pkg::CMD_PEEK, 8'h00, 4'h0);
    queue_word(cdq_pkg::CMD_POP, 8'h00, 4'h0);
    queue_word(cdq_pkg::CMD_OVERWRITE, 8'h81, 4'h0);
    queue_word(cdq_pkg::CMD_CLEAR, 8'h00, 4'h0);
    queue_word(cdq_pkg::CMD_POP, 8'hFF, 4'hF);
    queue_word(4'd9, 8'h00, 4'h0);
    queue_word(4'd15, 8'hFF, 4'hF);
    queue_word(cdq_pkg::CMD_PUSH_FRONT, 8'hFF, 4'h0);
    queue_pause();

    // Random part: bursts that fill the deque past full, drain it past empty,
    // and mixed traffic in between.
    while (random_count < RANDOM_WORDS) begin
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        n = $urandom_range(8, 20);
        for (j = 0; j < n; j++) begin
          queue_word($urandom_range(0, 1) ? cdq_pkg::CMD_PUSH_REAR
                                          : cdq_pkg::CMD_PUSH_FRONT,
                     pick_byte(), 4'($urandom_range(0, 15)));
          random_count++;
        end
      end else if (kind < 45) begin
        n = $urandom_range(4, 18);
        for (j = 0; j < n; j++) begin
          queue_word(($urandom_range(0, 5) == 0) ? cdq_pkg::CMD_PEEK : cdq_pkg::CMD_POP,
                     pick_byte(), 4'($urandom_range(0, 15)));
          random_count++;
        end
      end else if (kind < 92) begin
        n = $urandom_range(8, 30);
        for (j = 0; j < n; j++) begin
          queue_word(pick_command(), pick_byte(), 4'($urandom_range(0, 15)));
          random_count++;
        end
      end else if (kind < 97) begin
        queue_word(cdq_pkg::CMD_CLEAR, pick_byte(), 4'($urandom_range(0, 15)));
        random_count++;
      end else begin
        queue_pause();
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_words.size() != 0 || in_valid || word_ready || drain_wait)
      @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("circular_char_deque verification clean");
    end else begin
      $display("circular_char_deque verification failed");
    end
    $finish;
  end

endmodule
